// ===== hdl/rhpg_pkg.sv =====
// Shared constants, types and arithmetic helpers of the rainbow pixel generator.
`default_nettype none

package rhpg_pkg;

  localparam int LED_COUNT = 16;
  localparam int IDX_W     = 6;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [7:0]       SPACING  = 8'((256 / LED_COUNT) % 256);

  localparam logic [7:0] HUE_SECTOR = 8'd43;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [0:0] {
    FR_IDLE,
    FR_RUN
  } front_state_t;

  // One pixel request handed from the sequencer to the color converter
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [7:0]       hue;
    logic [7:0]       sat;
    logic [7:0]       val;
  } pix_req_t;

  // floor(x / 255) for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  // Hue to sector number (h / 43) and scaled remainder ((h % 43) * 6)
  function automatic logic [10:0] hue_split(input logic [7:0] h);
    logic [2:0] region;
    logic [7:0] base;
    logic [7:0] frac;
    region = 3'd0;
    base   = 8'd0;
    if (h >= 8'(5 * HUE_SECTOR)) begin
      region = 3'd5;
      base   = 8'(5 * HUE_SECTOR);
    end else if (h >= 8'(4 * HUE_SECTOR)) begin
      region = 3'd4;
      base   = 8'(4 * HUE_SECTOR);
    end else if (h >= 8'(3 * HUE_SECTOR)) begin
      region = 3'd3;
      base   = 8'(3 * HUE_SECTOR);
    end else if (h >= 8'(2 * HUE_SECTOR)) begin
      region = 3'd2;
      base   = 8'(2 * HUE_SECTOR);
    end else if (h >= HUE_SECTOR) begin
      region = 3'd1;
      base   = HUE_SECTOR;
    end
    frac = h - base;
    return {region, 8'({frac, 2'b00} + {1'b0, frac, 1'b0})};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rainbow_hsv_pixel_generator.sv =====
// Top level of the rainbow HSV pixel generator: sequencer, queue and converter.
//
//  channel | direction | tdata (low bit up)                          | tlast
//  in_     | request   | saturation[7:0], brightness[15:8]           | -
//  out_    | pixel     | pixel_index[5:0], red[13:6], green[21:14],  | last_pixel
//          |           | blue[29:22], zero[31:30]                    |
//
//  A frame request is accepted at the sequencer, which then puts one pixel request
//  per cycle into the queue while the queue is not full.
//  Each pixel passes through the register stages of the converter pipeline before it shows.
//  Reset clears the base hue to zero and empties queue and pipeline.
//  A stall on out_tready backs up the pipeline, then the queue, then the input.
`default_nettype none

module rainbow_hsv_pixel_generator
  import rhpg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // saturation[7:0], brightness[15:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // pixel_index[5:0], red, green, blue, zero pad
  output logic             out_tlast
);

  pix_req_t         fq_data, qb_data;
  logic             fq_push, fq_full;
  logic             qb_valid, qb_pop;
  logic [IDX_W-1:0] pix_idx;
  logic [7:0]       pix_red, pix_green, pix_blue;

  rhpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sat    (in_tdata[7:0]),
    .in_val    (in_tdata[15:8]),
    .q_push    (fq_push),
    .q_full    (fq_full),
    .q_data    (fq_data)
  );

  rhpg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (qb_pop),
    .not_empty (qb_valid),
    .pop_data  (qb_data)
  );

  rhpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_pop      (qb_pop),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_idx    (pix_idx),
    .out_red    (pix_red),
    .out_green  (pix_green),
    .out_blue   (pix_blue),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, pix_blue, pix_green, pix_red, pix_idx};

endmodule

`default_nettype wire

// ===== hdl/rhpg_front.sv =====
// Frame sequencer: takes a frame request and issues one hue request per LED.
`default_nettype none

module rhpg_front
  import rhpg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [7:0] in_sat,
  input  wire logic [7:0] in_val,
  output logic          q_push,
  input  wire logic     q_full,
  output pix_req_t      q_data
);

  front_state_t     state_r, state_nxt;
  logic [7:0]       sat_r, val_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       hue_r;
  logic [7:0]       base_hue_r;
  logic             accept;
  logic             last_push;

  assign accept    = in_tvalid && in_tready;
  assign last_push = q_push && (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (in_tvalid) state_nxt = FR_RUN;
      FR_RUN:  if (last_push) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    q_push    = 1'b0;
    case (state_r)
      FR_IDLE: in_tready = 1'b1;
      FR_RUN:  q_push    = !q_full;
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    q_data.idx  = idx_r;
    q_data.last = (idx_r == LAST_IDX);
    q_data.hue  = hue_r;
    q_data.sat  = sat_r;
    q_data.val  = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      base_hue_r <= 8'd0;
    end else begin
      state_r <= state_nxt;
      // advance the base hue once the frame's final request is out
      if (last_push) base_hue_r <= base_hue_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sat_r <= in_sat;
      val_r <= in_val;
      idx_r <= '0;
      hue_r <= base_hue_r;
    end else if (q_push) begin
      idx_r <= idx_r + IDX_W'(1);
      hue_r <= hue_r + SPACING;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rhpg_fifo.sv =====
// Short request queue between the frame sequencer and the color converter.
`default_nettype none

module rhpg_fifo
  import rhpg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  pix_req_t      push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output pix_req_t      pop_data
);

  pix_req_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hdl/rhpg_back.sv =====
// HSV to RGB converter pipeline with a registered result stage.
`default_nettype none

module rhpg_back
  import rhpg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  output logic          q_pop,
  input  pix_req_t      q_data,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [IDX_W-1:0] out_idx,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          out_last
);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [2:0]       region;
    logic [7:0]       sat;
    logic [7:0]       val;
  } pix_ctl_t;

  // stage 1: sector and remainder
  pix_ctl_t   c1_r;
  logic [7:0] rem1_r;
  // stage 2: first products
  pix_ctl_t   c2_r;
  logic [15:0] sr_prod2_r, st_prod2_r, p_prod2_r;
  // stage 3: scaled terms
  pix_ctl_t   c3_r;
  logic [7:0] p3_r, qf3_r, tf3_r;
  // stage 4: second products
  pix_ctl_t   c4_r;
  logic [7:0] p4_r;
  logic [15:0] q_prod4_r, t_prod4_r;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  logic [10:0] split;
  logic [7:0]  q4, t4;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [7:0]  red_r, green_r, blue_r;
  logic [IDX_W-1:0] idx_r;
  logic        last_r;

  assign rdyo  = !vo_r || out_tready;
  assign rdy4  = !v4_r || rdyo;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign q_pop = q_valid && rdy1;

  assign split = hue_split(q_data.hue);
  assign q4    = div255(q_prod4_r);
  assign t4    = div255(t_prod4_r);

  always_comb begin
    red_nxt   = c4_r.val;
    green_nxt = c4_r.val;
    blue_nxt  = c4_r.val;
    if (c4_r.sat != 8'd0) begin
      case (c4_r.region)
        3'd0: begin red_nxt = c4_r.val; green_nxt = t4;       blue_nxt = p4_r;     end
        3'd1: begin red_nxt = q4;       green_nxt = c4_r.val; blue_nxt = p4_r;     end
        3'd2: begin red_nxt = p4_r;     green_nxt = c4_r.val; blue_nxt = t4;       end
        3'd3: begin red_nxt = p4_r;     green_nxt = q4;       blue_nxt = c4_r.val; end
        3'd4: begin red_nxt = t4;       green_nxt = p4_r;     blue_nxt = c4_r.val; end
        default: begin red_nxt = c4_r.val; green_nxt = p4_r;  blue_nxt = q4;       end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= q_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_r.idx    <= q_data.idx;
      c1_r.last   <= q_data.last;
      c1_r.region <= split[10:8];
      c1_r.sat    <= q_data.sat;
      c1_r.val    <= q_data.val;
      rem1_r      <= split[7:0];
    end
    if (rdy2) begin
      c2_r       <= c1_r;
      sr_prod2_r <= c1_r.sat * rem1_r;
      st_prod2_r <= c1_r.sat * (FULL_SCALE - rem1_r);
      p_prod2_r  <= c1_r.val * (FULL_SCALE - c1_r.sat);
    end
    if (rdy3) begin
      c3_r  <= c2_r;
      p3_r  <= div255(p_prod2_r);
      qf3_r <= FULL_SCALE - div255(sr_prod2_r);
      tf3_r <= FULL_SCALE - div255(st_prod2_r);
    end
    if (rdy4) begin
      c4_r      <= c3_r;
      p4_r      <= p3_r;
      q_prod4_r <= c3_r.val * qf3_r;
      t_prod4_r <= c3_r.val * tf3_r;
    end
    if (rdyo) begin
      idx_r   <= c4_r.idx;
      last_r  <= c4_r.last;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_idx    = idx_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the rainbow HSV pixel generator.
`timescale 1ns / 1ps

module tb;
  import rhpg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 200;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int unsigned {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } hue_sector_t;

  typedef struct {
    bit [IDX_W-1:0] index;
    bit [7:0]       red;
    bit [7:0]       green;
    bit [7:0]       blue;
    bit             last;
  } pixel_t;

  class rainbow_scoreboard;
    bit [7:0] base_hue;
    pixel_t   pending_pixels[$];
    int       errors;

    function new();
      base_hue = 8'd0;
      errors = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void convert_color(input bit [7:0] h, input bit [7:0] s, input bit [7:0] v,
                                output bit [7:0] r, output bit [7:0] g, output bit [7:0] b);
      int unsigned rem;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      hue_sector_t sector;
      if (s == 8'd0) begin
        r = v;
        g = v;
        b = v;
        return;
      end
      sector = hue_sector_t'(h / 43);
      rem = (h % 43) * 6;
      p = v * (255 - s) / 255;
      q = v * (255 - s * rem / 255) / 255;
      t = v * (255 - s * (255 - rem) / 255) / 255;
      case (sector)
        SEC_RED: begin
          r = v; g = t[7:0]; b = p[7:0];
        end
        SEC_YELLOW: begin
          r = q[7:0]; g = v; b = p[7:0];
        end
        SEC_GREEN: begin
          r = p[7:0]; g = v; b = t[7:0];
        end
        SEC_CYAN: begin
          r = p[7:0]; g = q[7:0]; b = v;
        end
        SEC_BLUE: begin
          r = t[7:0]; g = p[7:0]; b = v;
        end
        default: begin
          r = v; g = p[7:0]; b = q[7:0];
        end
      endcase
    endfunction

    // Queue one frame of pixels, then advance the base hue
    function void note_request(input bit [15:0] request);
      bit [7:0] sat;
      bit [7:0] val;
      bit [7:0] spacing;
      bit [7:0] hue;
      pixel_t   px;
      sat = request[7:0];
      val = request[15:8];
      spacing = 8'((256 / LED_COUNT) % 256);
      for (int i = 0; i < LED_COUNT; i++) begin
        hue = base_hue + 8'(i * spacing);
        px.index = IDX_W'(i);
        px.last = (i == LED_COUNT - 1);
        convert_color(hue, sat, val, px.red, px.green, px.blue);
        pending_pixels.push_back(px);
      end
      base_hue = base_hue + 8'd1;
    endfunction

    function void compare_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_pixel(input bit [31:0] data, input bit last);
      pixel_t px;
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing expected: tdata %h, tlast %0d", data, last);
        errors++;
        return;
      end
      px = pending_pixels.pop_front();
      compare_field("pixel_index", px.index, data[5:0]);
      compare_field("red", px.red, data[13:6]);
      compare_field("green", px.green, data[21:14]);
      compare_field("blue", px.blue, data[29:22]);
      compare_field("last_pixel", px.last, last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;  // saturation[7:0], brightness[15:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // pixel_index[5:0], red, green, blue, zero pad
  logic        out_tlast;

  rainbow_scoreboard sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int ready_count = 0;

  rainbow_hsv_pixel_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Receiver stall pattern: switch between four ready modes chosen at random
  always @(negedge clk) begin
    ready_count <= ready_count + 1;
    if (ready_count % 64 == 0) begin
      ready_mode <= $urandom_range(0, 3);
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= (ready_count % 4 != 0);
      default: out_tready <= (ready_count % 32 >= 12);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_pixel(out_tdata, out_tlast);
      end
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Issue one frame request; open a new burst after a random gap
  task automatic send_request(input bit [7:0] sat, input bit [7:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {val, sat};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit [7:0] sat;
    bit [7:0] val;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes, grey frames and mid-scale values
    send_request(8'd0, 8'd0);
    send_request(8'd0, 8'd255);
    send_request(8'd0, 8'd128);
    send_request(8'd255, 8'd255);
    send_request(8'd255, 8'd0);
    send_request(8'd1, 8'd255);
    send_request(8'd254, 8'd255);
    send_request(8'd255, 8'd1);
    send_request(8'd128, 8'd128);
    send_request(8'h55, 8'hAA);
    send_request(8'hAA, 8'h55);
    send_request(8'd1, 8'd1);
    send_request(8'd255, 8'd254);

    // Hold off until every pixel is out
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      sat = $urandom_range(0, 255);
      val = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0: sat = 8'd0;
        1: sat = 8'd255;
        2: val = 8'd255;
        default: ;
      endcase
      send_request(sat, val);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
